[src/register_alu_with_nzcv_flags_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the NZCV register ALU.
// Each macro expects clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef REGISTER_ALU_WITH_NZCV_FLAGS_UNIT_MACROS_SVH
`define REGISTER_ALU_WITH_NZCV_FLAGS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NZALU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NZALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/nzalu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nzalu_pkg
// Operation codes and payload types shared by the NZCV register ALU files.
// ----------------------------------------------------------------------------
package nzalu_pkg;

    localparam int unsigned DataWidth = 32;

    // Operation codes in the order of opcode bits 6 to 9.
    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_LSL = 4'd2,
        OP_LSR = 4'd3,
        OP_ASR = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_ROR = 4'd7,
        OP_TST = 4'd8,
        OP_NEG = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MUL = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } alu_op_t;

    typedef struct packed {
        alu_op_t                alu_op;
        logic [DataWidth-1:0]   operand_d;
        logic [DataWidth-1:0]   operand_m;
        logic                   neg_in;
        logic                   zero_in;
        logic                   carry_in;
        logic                   overflow_in;
    } alu_in_t;

    typedef struct packed {
        logic [DataWidth-1:0]   result_value;
        logic                   write_back;
        logic                   neg_out;
        logic                   zero_out;
        logic                   carry_out;
        logic                   overflow_out;
    } alu_out_t;

endpackage

[src/nzalu_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nzalu_in_if / nzalu_out_if
// Valid/ready channels that carry ALU commands and ALU results.
// ----------------------------------------------------------------------------
interface nzalu_in_if;
    import nzalu_pkg::*;

    logic    valid;
    logic    ready;
    alu_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nzalu_out_if;
    import nzalu_pkg::*;

    logic     valid;
    logic     ready;
    alu_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/register_alu_with_nzcv_flags_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_alu_with_nzcv_flags_unit
// Sixteen-operation register ALU with NZCV flag update, two register stages.
// ----------------------------------------------------------------------------
//
//  Channel | Role   | Payload
//  --------+--------+-----------------------------------------------------
//  cmd     | sink   | alu_op, operand_d, operand_m, incoming NZCV flags
//  rsp     | source | result_value, write_back, updated NZCV flags
//
// Each command is held in the input register while the logic works on it
// and lands in the result register when the input stage advances, where its
// result is offered on rsp; one command is taken every cycle while rsp is
// not stalled.
// The longest path is the 32 by 32 multiplier feeding the result register.
// Reset clears both valid bits; the data registers are not reset.
// When rsp is stalled the result register holds, and the input register
// holds too once it is full, so cmd.ready drops only when both are full.
//
module register_alu_with_nzcv_flags_unit (
    input  logic         clk,
    input  logic         rst_n,
    nzalu_in_if.sink     cmd,
    nzalu_out_if.source  rsp
);
    import nzalu_pkg::*;

    // ------------------------------------------------------------------
    // Pipeline control. The input stage moves forward whenever the result
    // register is empty or its content is being taken in this cycle.
    // ------------------------------------------------------------------
    logic     in_valid_reg;
    logic     out_valid_reg;
    alu_in_t  in_reg;
    alu_out_t out_reg;
    alu_out_t out_next;
    logic     in_advance;
    logic     cmd_xfer;

    assign in_advance = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready  = !in_valid_reg || in_advance;
    assign cmd_xfer   = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (!out_valid_reg || rsp.ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            in_reg <= cmd.data;
        end
        if (in_advance)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // ------------------------------------------------------------------
    // Shifter. The amount is the low byte of operand_m. LSL, LSR and ASR use a
    // 33-bit window so the last bit shifted out falls into a spare bit.
    // ------------------------------------------------------------------
    logic [7:0]             shift_amt;
    logic [4:0]             shift_lo;
    logic                   amt_is_zero;
    logic                   amt_below_32;
    logic                   amt_is_32;
    logic [DataWidth:0]     lsl_win;
    logic [DataWidth:0]     lsr_win;
    logic [DataWidth:0]     asr_win;
    logic [2*DataWidth-1:0] ror_win;
    logic [DataWidth-1:0]   ror_val;
    logic [DataWidth-1:0]   shift_val;
    logic                   shift_carry;
    logic [DataWidth-1:0]   d_val;
    logic                   d_sign;

    assign d_val        = in_reg.operand_d;
    assign d_sign       = d_val[DataWidth-1];
    assign shift_amt    = in_reg.operand_m[7:0];
    assign shift_lo     = shift_amt[4:0];
    assign amt_is_zero  = (shift_amt == 8'd0);
    assign amt_below_32 = (shift_amt[7:5] == 3'd0);
    assign amt_is_32    = (shift_amt == 8'd32);

    assign lsl_win = {1'b0, d_val} << shift_lo;
    assign lsr_win = {d_val, 1'b0} >> shift_lo;
    assign asr_win = $unsigned($signed({d_val, 1'b0}) >>> shift_lo);
    assign ror_win = {d_val, d_val} >> shift_lo;
    assign ror_val = ror_win[DataWidth-1:0];

    always_comb
    begin
        shift_val   = d_val;
        shift_carry = in_reg.carry_in;
        if (!amt_is_zero)
        begin
            case (in_reg.alu_op)
                OP_LSL:
                begin
                    shift_val   = amt_below_32 ? lsl_win[DataWidth-1:0] : '0;
                    shift_carry = amt_below_32 ? lsl_win[DataWidth] :
                                  (amt_is_32 ? d_val[0] : 1'b0);
                end
                OP_LSR:
                begin
                    shift_val   = amt_below_32 ? lsr_win[DataWidth:1] : '0;
                    shift_carry = amt_below_32 ? lsr_win[0] :
                                  (amt_is_32 ? d_sign : 1'b0);
                end
                OP_ASR:
                begin
                    shift_val   = amt_below_32 ? asr_win[DataWidth:1] : {DataWidth{d_sign}};
                    shift_carry = amt_below_32 ? asr_win[0] : d_sign;
                end
                default:
                begin
                    // Rotate: a multiple of 32 leaves the value as it is,
                    // and the carry is always the new top bit.
                    shift_val   = ror_val;
                    shift_carry = ror_val[DataWidth-1];
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Adder shared by ADC, SBC, NEG, CMP and CMN. Subtraction is done as
    // a + ~b + carry, so a carry of one means no borrow.
    // ------------------------------------------------------------------
    logic [DataWidth-1:0] add_a;
    logic [DataWidth-1:0] add_b;
    logic                 add_cin;
    logic [DataWidth:0]   add_sum;
    logic                 add_v;

    always_comb
    begin
        add_a   = d_val;
        add_b   = in_reg.operand_m;
        add_cin = in_reg.carry_in;
        case (in_reg.alu_op)
            OP_SBC:
            begin
                add_b = ~in_reg.operand_m;
            end
            OP_NEG:
            begin
                add_a   = '0;
                add_b   = ~in_reg.operand_m;
                add_cin = 1'b1;
            end
            OP_CMP:
            begin
                add_b   = ~in_reg.operand_m;
                add_cin = 1'b1;
            end
            OP_CMN:
            begin
                add_cin = 1'b0;
            end
            default:
            begin
                add_cin = in_reg.carry_in;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{DataWidth{1'b0}}, add_cin};
    assign add_v   = ~(add_a[DataWidth-1] ^ add_b[DataWidth-1])
                   & (add_a[DataWidth-1] ^ add_sum[DataWidth-1]);

    // ------------------------------------------------------------------
    // Multiplier: only the low word of the product is kept.
    // ------------------------------------------------------------------
    logic [DataWidth-1:0] mul_lo;

    assign mul_lo = d_val * in_reg.operand_m;

    // ------------------------------------------------------------------
    // Result selection and flag update.
    // ------------------------------------------------------------------
    logic [DataWidth-1:0] res_val;
    logic                 res_c;
    logic                 res_v;

    always_comb
    begin
        res_val = '0;
        res_c   = in_reg.carry_in;
        res_v   = in_reg.overflow_in;
        case (in_reg.alu_op)
            OP_AND, OP_TST:
            begin
                res_val = d_val & in_reg.operand_m;
            end
            OP_EOR:
            begin
                res_val = d_val ^ in_reg.operand_m;
            end
            OP_LSL, OP_LSR, OP_ASR, OP_ROR:
            begin
                res_val = shift_val;
                res_c   = shift_carry;
            end
            OP_ADC, OP_SBC, OP_NEG, OP_CMP, OP_CMN:
            begin
                res_val = add_sum[DataWidth-1:0];
                res_c   = add_sum[DataWidth];
                res_v   = add_v;
            end
            OP_ORR:
            begin
                res_val = d_val | in_reg.operand_m;
            end
            OP_MUL:
            begin
                res_val = mul_lo;
            end
            OP_BIC:
            begin
                res_val = d_val & ~in_reg.operand_m;
            end
            default:
            begin
                res_val = ~in_reg.operand_m;
            end
        endcase
    end

    always_comb
    begin
        out_next.result_value = res_val;
        out_next.write_back   = !(in_reg.alu_op inside {OP_TST, OP_CMP, OP_CMN});
        out_next.neg_out      = res_val[DataWidth-1];
        out_next.zero_out     = (res_val == '0);
        out_next.carry_out    = res_c;
        out_next.overflow_out = res_v;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
`include "register_alu_with_nzcv_flags_unit_macros.svh"

    `NZALU_ASSERT_NEXT(a_cmd_lands, cmd_xfer, in_valid_reg, "accepted command was lost")
    `NZALU_ASSERT_NEXT(a_in_moves, in_advance, out_valid_reg, "advanced command did not reach rsp")
    `NZALU_ASSERT_NEXT(a_in_holds, in_valid_reg && !in_advance,
        in_valid_reg && $stable(in_reg), "stalled input register changed")
    `NZALU_ASSERT_SAME(a_nz_flags, out_valid_reg,
        (out_reg.neg_out == out_reg.result_value[DataWidth-1]) &&
        (out_reg.zero_out == (out_reg.result_value == '0)), "N or Z flag mismatch")

endmodule
